@@ rtl/accent_pitch_contour_macros.svh @@
// Assertion macros for the accent pitch contour RTL.
// Expect clk_i and rst_ni in the scope of each use.
`ifndef ACCENT_PITCH_CONTOUR_MACROS_SVH
`define ACCENT_PITCH_CONTOUR_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define APC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition is never true outside reset.
`define APC_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ rtl/apc_pkg.sv @@
// Shared types, codes and constants of the accent pitch contour block.
// No dependencies.
package apc_pkg;

  localparam int unsigned MaxSegmentsDef = 1024;
  localparam int unsigned SegIdxW  = 10;
  localparam int unsigned PitchW   = 16;
  localparam int unsigned FrameW   = 32;
  localparam int unsigned PeriodW  = 17;
  localparam int unsigned MulXW    = 36;
  localparam int unsigned MulHalfW = 18;
  localparam int unsigned MulPW    = MulHalfW + PeriodW;
  localparam int unsigned AccW     = MulXW + PeriodW;
  localparam int unsigned DivNumW  = 55;
  localparam int unsigned DivDenW  = MulXW + 1;
  localparam int unsigned DivQW    = 17;
  localparam int unsigned QDepth   = 2;

  localparam logic [PeriodW-1:0] RampCapUs = 17'd100000;

  localparam logic [PitchW-1:0]  RstLvlAnudatta = 16'd18842;
  localparam logic [PitchW-1:0]  RstLvlUdatta   = 16'd20070;
  localparam logic [PitchW-1:0]  RstLvlSvEnd    = 16'd18842;
  localparam logic [PitchW-1:0]  RstLvlSvStart  = 16'd20070;
  localparam logic [PitchW-1:0]  RstLvlSann     = 16'd18842;
  localparam logic [PeriodW-1:0] RstPeriodUs    = 17'd5000;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_QUERY = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    CLS_A     = 3'd0,
    CLS_U     = 3'd1,
    CLS_S     = 3'd2,
    CLS_V     = 3'd3,
    CLS_OTHER = 3'd4
  } cls_e;

  typedef enum logic [2:0] {
    CFG_LVL_ANUDATTA = 3'd0,
    CFG_LVL_UDATTA   = 3'd1,
    CFG_LVL_SV_END   = 3'd2,
    CFG_LVL_SV_START = 3'd3,
    CFG_LVL_SANN     = 3'd4,
    CFG_PERIOD_US    = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]        mode;
    logic [2:0]        seg_class;
    logic              left_is_udatta;
    logic              right_is_anudatta;
    logic              geminate;
    logic [15:0]       seg_frames;
    logic [FrameW-1:0] frame_index;
  } in_item_t;

  typedef struct packed {
    logic [PitchW-1:0]  pitch;
    logic [SegIdxW-1:0] segment_index;
  } out_item_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [2:0]        cls;
    logic              left;
    logic              right;
    logic              gem;
    logic [15:0]       seg_frames;
    logic [FrameW-1:0] frame;
  } q_item_t;

  typedef struct packed {
    logic [2:0]        cls;
    logic              left;
    logic              right;
    logic              gem;
    logic [FrameW-1:0] seg_end;
  } seg_entry_t;

  typedef struct packed {
    logic [PitchW-1:0]  lvl_a;
    logic [PitchW-1:0]  lvl_u;
    logic [PitchW-1:0]  lvl_sv_end;
    logic [PitchW-1:0]  lvl_sv_start;
    logic [PitchW-1:0]  lvl_sann;
    logic [PeriodW-1:0] period;
  } cfg_t;

  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [DivQW-1:0] quot;
  } div_rsp_t;

endpackage

@@ rtl/accent_pitch_contour.sv @@
// Accent pitch contour: a query walks w segments through the single table read
// port, then gives a fixed level or a ramp that uses the 17-step divider.
// One transaction is worked on at a time; a two-entry queue decouples the input.
// Reset clears the table count and pointer and restores the default levels and
// frame period; no clearing pass is run. Depends on apc_pkg, apc_front and apc_back.
module accent_pitch_contour import apc_pkg::*; #(
  parameter int unsigned MaxSegments = MaxSegmentsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  in_item_t           in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output out_item_t          out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [PeriodW-1:0] cfg_data_i
);

  cfg_t    cfg_q, cfg_d;
  logic    q_valid, q_pop;
  q_item_t q_item;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LVL_ANUDATTA: cfg_d.lvl_a        = cfg_data_i[PitchW-1:0];
        CFG_LVL_UDATTA:   cfg_d.lvl_u        = cfg_data_i[PitchW-1:0];
        CFG_LVL_SV_END:   cfg_d.lvl_sv_end   = cfg_data_i[PitchW-1:0];
        CFG_LVL_SV_START: cfg_d.lvl_sv_start = cfg_data_i[PitchW-1:0];
        CFG_LVL_SANN:     cfg_d.lvl_sann     = cfg_data_i[PitchW-1:0];
        CFG_PERIOD_US:    cfg_d.period       = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{lvl_a: RstLvlAnudatta, lvl_u: RstLvlUdatta, lvl_sv_end: RstLvlSvEnd,
                 lvl_sv_start: RstLvlSvStart, lvl_sann: RstLvlSann,
                 period: RstPeriodUs};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  apc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_item_o   (q_item)
  );

  apc_back #(
    .MaxSegments (MaxSegments)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

@@ rtl/apc_front.sv @@
// Input side: accept transactions, classify by mode, queue commands.
// Depends on apc_pkg.
module apc_front import apc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_item_i,
  output logic     q_valid_o,
  input  logic     q_pop_i,
  output q_item_t  q_item_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  q_item_t         store_q [QDepth];
  q_item_t         new_item;
  logic            keep, push;

  assign in_stall_o = (cnt_q == CntW'(QDepth));
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = store_q[rd_ptr_q];

  always_comb begin
    keep = 1'b1;
    new_item.cmd        = CMD_START;
    new_item.cls        = in_item_i.seg_class;
    new_item.left       = in_item_i.left_is_udatta;
    new_item.right      = in_item_i.right_is_anudatta;
    new_item.gem        = in_item_i.geminate;
    new_item.seg_frames = in_item_i.seg_frames;
    new_item.frame      = in_item_i.frame_index;
    case (in_item_i.mode)
      MODE_START: new_item.cmd = CMD_START;
      MODE_LOAD:  new_item.cmd = CMD_LOAD;
      MODE_QUERY: new_item.cmd = CMD_QUERY;
      default:    keep = 1'b0;
    endcase
    push = in_valid_i && !in_stall_o && keep;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push);
    rd_ptr_d = rd_ptr_q + PtrW'(q_pop_i);
    cnt_d    = cnt_q + CntW'(push) - CntW'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      cnt_q    <= cnt_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      store_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

@@ rtl/apc_div.sv @@
// Restoring divider with an overflow flag, one quotient bit per cycle.
// Depends on apc_pkg.
module apc_div import apc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [DivNumW-1:0] num_i,
  input  logic [DivDenW-1:0] den_i,
  output div_rsp_t           rsp_o
);

  localparam int unsigned CntW = $clog2(DivQW);

  logic               busy_q, busy_d, done_q, done_d, ovf_q, ovf_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DivNumW-1:0] rem_q, rem_d, dsh_q, dsh_d;
  logic [DivQW-1:0]   quot_q, quot_d;
  logic [DivNumW-1:0] den_ext;

  assign den_ext = DivNumW'(den_i);
  assign rsp_o   = '{done: done_q, ovf: ovf_q, quot: quot_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    ovf_d  = ovf_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    if (start_i) begin
      if (num_i >= (den_ext << DivQW)) begin
        ovf_d  = 1'b1;
        done_d = 1'b1;
        busy_d = 1'b0;
      end else begin
        ovf_d  = 1'b0;
        rem_d  = num_i;
        dsh_d  = den_ext << (DivQW - 1);
        quot_d = '0;
        cnt_d  = CntW'(DivQW - 1);
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      if (rem_q >= dsh_q) begin
        rem_d  = rem_q - dsh_q;
        quot_d = {quot_q[DivQW-2:0], 1'b1};
      end else begin
        quot_d = {quot_q[DivQW-2:0], 1'b0};
      end
      dsh_d = dsh_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ovf_q  <= ovf_d;
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quot_q <= quot_d;
  end

endmodule

@@ rtl/apc_back.sv @@
// Execution side: segment table, pointer walk, level selection and ramps.
// Depends on apc_pkg, apc_div and the assertion macro header.
`include "accent_pitch_contour_macros.svh"
module apc_back import apc_pkg::*; #(
  parameter int unsigned MaxSegments = MaxSegmentsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  output logic      q_pop_o,
  input  q_item_t   q_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  localparam int unsigned IW = $clog2(MaxSegments);
  localparam int unsigned CW = $clog2(MaxSegments + 1);

  typedef enum logic [16:0] {
    ST_IDLE = 17'h00001,
    ST_WALK = 17'h00002,
    ST_RM1  = 17'h00004,
    ST_RM2  = 17'h00008,
    ST_RP1  = 17'h00010,
    ST_OPS  = 17'h00020,
    ST_DISP = 17'h00040,
    ST_TM1  = 17'h00080,
    ST_TM2  = 17'h00100,
    ST_EM1  = 17'h00200,
    ST_EM2  = 17'h00400,
    ST_SCMP = 17'h00800,
    ST_LM1  = 17'h01000,
    ST_LM2  = 17'h02000,
    ST_DVS  = 17'h04000,
    ST_DIV  = 17'h08000,
    ST_OUT  = 17'h10000
  } state_e;

  function automatic logic is_as(input logic [2:0] c);
    return (c == CLS_A) || (c == CLS_S);
  endfunction

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [IW-1:0]     cur_q, cur_d, k_q, k_d;
  logic [FrameW-1:0] seg_start_q, seg_start_d, run_end_q, run_end_d;
  logic [FrameW-1:0] f_q, f_d, len_q, len_d, off_q, off_d;
  seg_entry_t        ent_k_q, ent_k_d, ent_m1_q, ent_m1_d;
  seg_entry_t        ent_m2_q, ent_m2_d, ent_p1_q, ent_p1_d;
  logic              has_m1_q, has_m1_d, has_m2_q, has_m2_d, has_p1_q, has_p1_d;
  logic [AccW-1:0]   acc_q, acc_d;
  logic [PeriodW-1:0] t_q, t_d;
  logic [MulXW-1:0]  num_q, num_d, den_q, den_d;
  logic [PitchW-1:0] a_q, a_d, mag_q, mag_d, pitch_q, pitch_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_item_q, out_item_d;

  seg_entry_t        mem_q [MaxSegments];
  seg_entry_t        rd_q, wr_data;
  logic [IW-1:0]     rd_addr, wr_addr;
  logic              wr_en;

  logic              has_next;
  logic [FrameW:0]   load_sum;
  logic [MulXW-1:0]  mul_x;
  logic [PeriodW-1:0] mul_y;
  logic              mul_hi;
  logic [MulHalfW-1:0] mul_a;
  logic [MulPW-1:0]  prod;
  logic [AccW-1:0]   acc_sum;

  logic [PitchW-1:0] lp_a, lp_b;
  logic [MulXW-1:0]  lp_num, lp_den;
  logic [PitchW:0]   lp_diff;
  logic              lerp_go;

  logic [MulXW-1:0]  off10, len9, vnum, vden;
  logic              dlh;
  logic [PitchW-1:0] vp1, vp2;

  logic              div_start;
  div_rsp_t          div_rsp;
  logic [DivNumW-1:0] div_num;
  logic [DivDenW-1:0] div_den;
  logic [PitchW+1:0] up_sum;
  logic [PitchW-1:0] fin_pitch;

  assign has_next = (CW'(k_q) + CW'(1)) < count_q;
  assign load_sum = (FrameW+1)'(run_end_q) + (FrameW+1)'(q_item_i.seg_frames);
  assign wr_addr  = count_q[IW-1:0];
  assign mul_a    = mul_hi ? mul_x[MulXW-1:MulHalfW] : mul_x[MulHalfW-1:0];
  assign prod     = MulPW'(mul_a) * MulPW'(mul_y);
  assign acc_sum  = acc_q + (AccW'(prod) << MulHalfW);
  assign div_num  = (DivNumW'(acc_q) << 1) + DivNumW'(den_q);
  assign div_den  = {den_q, 1'b0};
  assign lp_diff  = (PitchW+1)'(lp_b) - (PitchW+1)'(lp_a);
  assign up_sum   = (PitchW+2)'(a_q) + (PitchW+2)'(div_rsp.quot);

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  always_comb begin
    if (neg_q) begin
      if (div_rsp.ovf || (div_rsp.quot > DivQW'(a_q))) begin
        fin_pitch = '0;
      end else begin
        fin_pitch = a_q - div_rsp.quot[PitchW-1:0];
      end
    end else if (div_rsp.ovf || up_sum[PitchW+1:PitchW] != '0) begin
      fin_pitch = '1;
    end else begin
      fin_pitch = up_sum[PitchW-1:0];
    end
  end

  always_comb begin
    off10 = (MulXW'(off_q) << 3) + (MulXW'(off_q) << 1);
    len9  = (MulXW'(len_q) << 3) + MulXW'(len_q);
    dlh   = ent_k_q.gem && (off10 > len9);
    vp1   = (ent_k_q.left || !ent_k_q.right) ? cfg_i.lvl_u : cfg_i.lvl_a;
    vp2   = vp1;
    if (has_m1_q) begin
      if (is_as(ent_m1_q.cls) && !dlh) begin
        vp1 = ent_m1_q.right ? cfg_i.lvl_a : cfg_i.lvl_sann;
        if (has_p1_q && (ent_p1_q.cls == CLS_V || ent_k_q.gem)) begin
          vp2 = cfg_i.lvl_a;
        end
      end
      if (ent_m1_q.cls == CLS_S && !dlh) begin
        vp1 = cfg_i.lvl_sv_end;
      end
      if (ent_m1_q.cls == CLS_V || dlh) begin
        if (has_m2_q && !dlh && is_as(ent_m2_q.cls)) begin
          vp1 = cfg_i.lvl_a;
        end
        if (dlh && is_as(ent_m1_q.cls)) begin
          vp1 = cfg_i.lvl_a;
        end
      end
    end
    if (has_p1_q && (!ent_k_q.gem || dlh)) begin
      if (ent_p1_q.cls == CLS_A) begin
        vp2 = ent_p1_q.right ? cfg_i.lvl_a : cfg_i.lvl_sann;
      end
      if (ent_p1_q.cls == CLS_S) begin
        vp2 = cfg_i.lvl_sv_start;
      end
    end
    if (!ent_k_q.gem) begin
      vnum = MulXW'(off_q);
      vden = MulXW'(len_q);
    end else if (!dlh) begin
      vnum = off10;
      vden = len9;
    end else begin
      vnum = off10 - len9;
      vden = len9;
    end
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cur_d       = cur_q;
    k_d         = k_q;
    seg_start_d = seg_start_q;
    run_end_d   = run_end_q;
    f_d         = f_q;
    len_d       = len_q;
    off_d       = off_q;
    ent_k_d     = ent_k_q;
    ent_m1_d    = ent_m1_q;
    ent_m2_d    = ent_m2_q;
    ent_p1_d    = ent_p1_q;
    has_m1_d    = has_m1_q;
    has_m2_d    = has_m2_q;
    has_p1_d    = has_p1_q;
    acc_d       = acc_q;
    t_d         = t_q;
    num_d       = num_q;
    den_d       = den_q;
    a_d         = a_q;
    mag_d       = mag_q;
    neg_d       = neg_q;
    pitch_d     = pitch_q;
    out_item_d  = out_item_q;
    out_valid_d = out_valid_q && out_stall_i;
    q_pop_o     = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = k_q;
    mul_x       = MulXW'(len_q);
    mul_y       = cfg_i.period;
    mul_hi      = 1'b0;
    lp_a        = cfg_i.lvl_sv_start;
    lp_b        = cfg_i.lvl_sv_end;
    lp_num      = vnum;
    lp_den      = vden;
    lerp_go     = 1'b0;
    div_start   = 1'b0;
    wr_data     = '{cls: q_item_i.cls, left: q_item_i.left, right: q_item_i.right,
                    gem: q_item_i.gem, seg_end: run_end_q};

    case (state_q)
      ST_IDLE: begin
        rd_addr = cur_q;
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          case (q_item_i.cmd)
            CMD_START: begin
              count_d     = '0;
              cur_d       = '0;
              seg_start_d = '0;
              run_end_d   = '0;
            end
            CMD_LOAD: begin
              if (count_q != CW'(MaxSegments)) begin
                run_end_d       = load_sum[FrameW] ? '1 : load_sum[FrameW-1:0];
                wr_data.seg_end = run_end_d;
                wr_en           = 1'b1;
                count_d         = count_q + CW'(1);
              end
            end
            CMD_QUERY: begin
              if (count_q != '0) begin
                f_d     = q_item_i.frame;
                k_d     = cur_q;
                state_d = ST_WALK;
              end
            end
            default: ;
          endcase
        end
      end
      ST_WALK: begin
        if ((f_q > rd_q.seg_end) && has_next) begin
          k_d         = k_q + IW'(1);
          seg_start_d = rd_q.seg_end;
          rd_addr     = k_q + IW'(1);
        end else begin
          ent_k_d = rd_q;
          cur_d   = k_q;
          rd_addr = k_q - IW'(1);
          state_d = ST_RM1;
        end
      end
      ST_RM1: begin
        ent_m1_d = rd_q;
        rd_addr  = k_q - IW'(2);
        state_d  = ST_RM2;
      end
      ST_RM2: begin
        ent_m2_d = rd_q;
        rd_addr  = k_q + IW'(1);
        state_d  = ST_RP1;
      end
      ST_RP1: begin
        ent_p1_d = rd_q;
        state_d  = ST_OPS;
      end
      ST_OPS: begin
        len_d    = (ent_k_q.seg_end >= seg_start_q) ? ent_k_q.seg_end - seg_start_q : '0;
        off_d    = (f_q >= seg_start_q) ? f_q - seg_start_q : '0;
        has_m1_d = (k_q != '0);
        has_m2_d = (CW'(k_q) > CW'(1));
        has_p1_d = has_next;
        state_d  = ST_DISP;
      end
      ST_DISP: begin
        case (ent_k_q.cls)
          CLS_A: begin
            pitch_d = ent_k_q.right ? cfg_i.lvl_a : cfg_i.lvl_sann;
            state_d = ST_OUT;
          end
          CLS_U: begin
            pitch_d = cfg_i.lvl_u;
            state_d = ST_OUT;
          end
          CLS_S: state_d = ST_TM1;
          CLS_V: begin
            if ((vp1 == vp2) || (len_q == '0)) begin
              pitch_d = vp1;
              state_d = ST_OUT;
            end else begin
              lp_a    = vp1;
              lp_b    = vp2;
              lerp_go = 1'b1;
              state_d = ST_LM1;
            end
          end
          default: begin
            pitch_d = cfg_i.lvl_a;
            state_d = ST_OUT;
          end
        endcase
      end
      ST_TM1: begin
        acc_d   = AccW'(prod);
        state_d = ST_TM2;
      end
      ST_TM2: begin
        mul_hi  = 1'b1;
        t_d     = (acc_sum > AccW'(RampCapUs)) ? RampCapUs : acc_sum[PeriodW-1:0];
        state_d = ST_EM1;
      end
      ST_EM1: begin
        mul_x   = MulXW'(off_q);
        acc_d   = AccW'(prod);
        state_d = ST_EM2;
      end
      ST_EM2: begin
        mul_x   = MulXW'(off_q);
        mul_hi  = 1'b1;
        acc_d   = acc_sum;
        state_d = ST_SCMP;
      end
      ST_SCMP: begin
        if (acc_q < AccW'(t_q)) begin
          lp_num  = MulXW'(acc_q[PeriodW-1:0]);
          lp_den  = MulXW'(t_q);
          lerp_go = 1'b1;
          state_d = ST_LM1;
        end else begin
          pitch_d = cfg_i.lvl_sv_end;
          state_d = ST_OUT;
        end
      end
      ST_LM1: begin
        mul_x   = num_q;
        mul_y   = PeriodW'(mag_q);
        acc_d   = AccW'(prod);
        state_d = ST_LM2;
      end
      ST_LM2: begin
        mul_x   = num_q;
        mul_y   = PeriodW'(mag_q);
        mul_hi  = 1'b1;
        acc_d   = acc_sum;
        state_d = ST_DVS;
      end
      ST_DVS: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          pitch_d = fin_pitch;
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_item_d  = '{pitch: pitch_q, segment_index: SegIdxW'(k_q)};
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (lerp_go) begin
      a_d   = lp_a;
      neg_d = lp_diff[PitchW];
      mag_d = lp_diff[PitchW] ? PitchW'((PitchW+1)'(0) - lp_diff) : lp_diff[PitchW-1:0];
      num_d = lp_num;
      den_d = lp_den;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      cur_q       <= '0;
      seg_start_q <= '0;
      run_end_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      cur_q       <= cur_d;
      seg_start_q <= seg_start_d;
      run_end_q   <= run_end_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q        <= k_d;
    f_q        <= f_d;
    len_q      <= len_d;
    off_q      <= off_d;
    ent_k_q    <= ent_k_d;
    ent_m1_q   <= ent_m1_d;
    ent_m2_q   <= ent_m2_d;
    ent_p1_q   <= ent_p1_d;
    has_m1_q   <= has_m1_d;
    has_m2_q   <= has_m2_d;
    has_p1_q   <= has_p1_d;
    acc_q      <= acc_d;
    t_q        <= t_d;
    num_q      <= num_d;
    den_q      <= den_d;
    a_q        <= a_d;
    mag_q      <= mag_d;
    neg_q      <= neg_d;
    pitch_q    <= pitch_d;
    out_item_q <= out_item_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rd_q <= mem_q[rd_addr];
  end

  apc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .rsp_o   (div_rsp)
  );

  `APC_ASSERT(a_cur_in_table, count_q != '0 |-> CW'(cur_q) < count_q, "pointer past table")
  `APC_ASSERT(a_start_le_end, seg_start_q <= run_end_q, "segment start beyond running end")
  `APC_NEVER(a_count_bound, count_q > CW'(MaxSegments), "segment count beyond capacity")
  `APC_ASSERT(a_out_from_seq, !$past(out_valid_q) && out_valid_q |-> $past(state_q == ST_OUT),
              "result raised outside output step")

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for accent_pitch_contour: drives segment tables and frame
// queries, predicts every pitch and segment index and checks each output transaction.
// Depends on apc_pkg and the accent_pitch_contour RTL.
`timescale 1ns / 100ps

module testbench;
  import apc_pkg::*;

  localparam int unsigned TableDepth = 1024;
  localparam logic [1:0] MODE_RESERVED = 2'd3;
  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [2:0] cfg_index_i = '0;
  logic [PeriodW-1:0] cfg_data_i = '0;

  accent_pitch_contour DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .in_item_i,
    .out_valid_o, .out_stall_i, .out_item_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // contour model state
  logic [15:0] lvl_a, lvl_u, lvl_sv_end, lvl_sv_start, lvl_sann;
  logic [16:0] period_us;
  logic [2:0] t_cls [TableDepth];
  bit t_left [TableDepth];
  bit t_right [TableDepth];
  bit t_gem [TableDepth];
  logic [31:0] t_end [TableDepth];
  int unsigned seg_count, cur_seg;
  logic [31:0] seg_start, run_end;

  out_item_t expected_contour[$];
  int mismatches = 0;
  int sender_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic logic [15:0] sat16(longint v);
    if (v < 0) return 16'd0;
    if (v > 65535) return 16'hFFFF;
    return v[15:0];
  endfunction

  function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b,
                                        longint unsigned num, longint unsigned den);
    longint d;
    longint unsigned mag, q;
    d = longint'(b) - longint'(a);
    mag = d < 0 ? -d : d;
    q = (mag * num * 2 + den) / (2 * den);
    return sat16(longint'(a) + (d < 0 ? -longint'(q) : longint'(q)));
  endfunction

  function automatic bit is_low(logic [2:0] c);
    return c == CLS_A || c == CLS_S;
  endfunction

  function automatic logic [15:0] vowel_level(int unsigned k, longint unsigned off,
                                              longint unsigned len);
    bit gem, dlh;
    logic [15:0] p1, p2;
    logic [2:0] pc, nc;
    gem = t_gem[k];
    dlh = gem && (off * 10 > len * 9);
    p1 = (t_left[k] || !t_right[k]) ? lvl_u : lvl_a;
    p2 = p1;
    if (k > 0) begin
      pc = t_cls[k-1];
      if (is_low(pc) && !dlh) begin
        p1 = t_right[k-1] ? lvl_a : lvl_sann;
        if (k + 1 < seg_count && (t_cls[k+1] == CLS_V || gem)) p2 = lvl_a;
      end
      if (pc == CLS_S && !dlh) p1 = lvl_sv_end;
      if (pc == CLS_V || dlh) begin
        if (k > 1 && !dlh && is_low(t_cls[k-2])) p1 = lvl_a;
        if (dlh && is_low(pc)) p1 = lvl_a;
      end
    end
    if (k + 1 < seg_count && (!gem || dlh)) begin
      nc = t_cls[k+1];
      if (nc == CLS_A) p2 = t_right[k+1] ? lvl_a : lvl_sann;
      if (nc == CLS_S) p2 = lvl_sv_start;
    end
    if (p1 == p2 || len == 0) return p1;
    if (!gem) return blend(p1, p2, off, len);
    if (!dlh) return blend(p1, p2, off * 10, len * 9);
    return blend(p1, p2, off * 10 - len * 9, len * 9);
  endfunction

  task automatic advance_contour(in_item_t it);
    logic [32:0] sum;
    int unsigned k;
    longint unsigned off, len, ramp, el;
    out_item_t r;
    if (it.mode == MODE_START) begin
      seg_count = 0; cur_seg = 0; seg_start = '0; run_end = '0;
    end else if (it.mode == MODE_LOAD) begin
      if (seg_count < TableDepth) begin
        sum = {1'b0, run_end} + it.seg_frames;
        run_end = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        t_cls[seg_count] = it.seg_class;
        t_left[seg_count] = it.left_is_udatta;
        t_right[seg_count] = it.right_is_anudatta;
        t_gem[seg_count] = it.geminate;
        t_end[seg_count] = run_end;
        seg_count++;
      end
    end else if (it.mode == MODE_QUERY && seg_count != 0) begin
      k = cur_seg;
      if (k >= seg_count) k = seg_count - 1;
      if (it.frame_index > t_end[k]) begin
        while (k + 1 < seg_count && it.frame_index > t_end[k]) k++;
        seg_start = k > 0 ? t_end[k-1] : '0;
      end
      cur_seg = k;
      len = t_end[k] >= seg_start ? 64'(t_end[k]) - 64'(seg_start) : 0;
      off = it.frame_index >= seg_start ? 64'(it.frame_index) - 64'(seg_start) : 0;
      case (t_cls[k])
        CLS_A: r.pitch = t_right[k] ? lvl_a : lvl_sann;
        CLS_U: r.pitch = lvl_u;
        CLS_S: begin
          ramp = len * period_us;
          el = off * period_us;
          if (ramp > RampCapUs) ramp = RampCapUs;
          r.pitch = el < ramp ? blend(lvl_sv_start, lvl_sv_end, el, ramp) : lvl_sv_end;
        end
        CLS_V: r.pitch = vowel_level(k, off, len);
        default: r.pitch = lvl_a;
      endcase
      r.segment_index = k[9:0];
      expected_contour.push_back(r);
    end
  endtask

  // receive side: stall pattern, long hold-off and result check
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_contour.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transaction %h", out_item_o);
      end else begin
        if (out_item_o.pitch !== expected_contour[0].pitch ||
            out_item_o.segment_index !== expected_contour[0].segment_index) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: pitch %0d seg %0d, expected pitch %0d seg %0d",
                     out_item_o.pitch, out_item_o.segment_index,
                     expected_contour[0].pitch, expected_contour[0].segment_index);
        end
        void'(expected_contour.pop_front());
      end
    end
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    advance_contour(it);
  endtask

  function automatic in_item_t make_item(logic [1:0] mode, logic [2:0] cls, bit left,
                                         bit right, bit gem, logic [15:0] frames,
                                         logic [31:0] frame);
    in_item_t it;
    it.mode = mode; it.seg_class = cls; it.left_is_udatta = left;
    it.right_is_anudatta = right; it.geminate = gem;
    it.seg_frames = frames; it.frame_index = frame;
    return it;
  endfunction

  task automatic load_seg(logic [2:0] cls, bit left, bit right, bit gem,
                          logic [15:0] frames);
    send_item(make_item(MODE_LOAD, cls, left, right, gem, frames, $urandom));
  endtask

  task automatic query_frame(logic [31:0] frame);
    send_item(make_item(MODE_QUERY, $urandom, $urandom, $urandom, $urandom,
                        $urandom, frame));
  endtask

  task automatic start_utterance();
    send_item(make_item(MODE_START, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom));
  endtask

  // drop valid and drain everything in flight
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_contour.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [16:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_LVL_ANUDATTA: lvl_a = data[15:0];
      CFG_LVL_UDATTA: lvl_u = data[15:0];
      CFG_LVL_SV_END: lvl_sv_end = data[15:0];
      CFG_LVL_SV_START: lvl_sv_start = data[15:0];
      CFG_LVL_SANN: lvl_sann = data[15:0];
      CFG_PERIOD_US: period_us = data;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic write_levels(logic [16:0] a, logic [16:0] u, logic [16:0] se,
                              logic [16:0] ss, logic [16:0] sn, logic [16:0] per);
    write_reg(CFG_LVL_ANUDATTA, a);
    write_reg(CFG_LVL_UDATTA, u);
    write_reg(CFG_LVL_SV_END, se);
    write_reg(CFG_LVL_SV_START, ss);
    write_reg(CFG_LVL_SANN, sn);
    write_reg(CFG_PERIOD_US, per);
  endtask

  task automatic test_directed();
    start_utterance();
    query_frame(32'd5);
    send_item(make_item(MODE_RESERVED, CLS_U, 1, 1, 1, 16'hFFFF, 32'hFFFF_FFFF));
    load_seg(CLS_A, 0, 1, 0, 16'd4);
    load_seg(CLS_V, 0, 1, 0, 16'd10);
    load_seg(CLS_S, 1, 0, 0, 16'd30);
    load_seg(CLS_V, 1, 0, 1, 16'd20);
    load_seg(CLS_V, 0, 0, 0, 16'd0);
    load_seg(CLS_U, 0, 0, 0, 16'd3);
    load_seg(3'd7, 1, 1, 1, 16'd2);
    load_seg(CLS_A, 0, 0, 0, 16'd0);
    load_seg(CLS_S, 0, 1, 1, 16'hFFFF);
    query_frame(32'd0);
    query_frame(32'd9);
    query_frame(32'd20);
    query_frame(32'd10);
    query_frame(32'd60);
    query_frame(32'd64);
    query_frame(32'd66);
    query_frame(32'd67);
    query_frame(32'd71);
    query_frame(32'd72);
    query_frame(32'd100);
    query_frame(32'hFFFF_FFFF);
    query_frame(32'd1);
  endtask

  task automatic test_full_table();
    start_utterance();
    for (int i = 0; i < TableDepth + 2; i++)
      load_seg($urandom_range(0, 7), $urandom, $urandom, $urandom, $urandom_range(0, 3));
    query_frame(32'd700);
    query_frame(32'hFFFF_FFFF);
  endtask

  task automatic random_utterance();
    int nseg;
    logic [31:0] frame;
    start_utterance();
    nseg = $urandom_range(1, 12);
    for (int i = 0; i < nseg; i++)
      load_seg($urandom_range(0, 9) < 8 ? $urandom_range(0, 4) : $urandom_range(5, 7),
               $urandom, $urandom, $urandom,
               $urandom_range(0, 19) == 0 ? 16'($urandom) : 16'($urandom_range(0, 40)));
    frame = $urandom_range(0, 3);
    repeat ($urandom_range(2, 16)) begin
      case ($urandom_range(0, 9))
        0: query_frame($urandom);
        1: query_frame(frame > 5 ? frame - 5 : 32'd0);
        2: send_item(make_item(MODE_RESERVED, $urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom));
        default: begin
          frame += $urandom_range(0, 8);
          query_frame(frame);
        end
      endcase
    end
  endtask

  task automatic test_random(int sender_pct, int rx_pct);
    int sent;
    sender_idle_pct = sender_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < 130) begin
      random_utterance();
      sent += 20;
    end
    settle();
  endtask

  task automatic test_backpressure();
    sender_idle_pct = 0;
    rx_stall_pct = 0;
    random_utterance();
    hold_cycles = 400;
    repeat (20) query_frame($urandom_range(0, 200));
    settle();
  endtask

  initial begin
    lvl_a = RstLvlAnudatta; lvl_u = RstLvlUdatta; lvl_sv_end = RstLvlSvEnd;
    lvl_sv_start = RstLvlSvStart; lvl_sann = RstLvlSann; period_us = RstPeriodUs;
    seg_count = 0; cur_seg = 0; seg_start = '0; run_end = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    settle();
    write_levels(17'd0, 17'h1FFFF, 17'd65535, 17'd0, 17'd30000, 17'd0);
    write_reg(CFG_SPARE_LO, 17'd5);
    write_reg(CFG_SPARE_HI, 17'h1FFFF);
    test_directed();
    settle();
    write_levels(17'd65535, 17'd0, 17'd0, 17'd65535, 17'd65535, 17'd1);
    test_directed();
    settle();
    write_levels(17'd12000, 17'd24000, 17'd10000, 17'd26000, 17'd14000, 17'h1FFFF);
    test_full_table();
    settle();

    write_levels(RstLvlAnudatta, RstLvlUdatta, RstLvlSvEnd, RstLvlSvStart, RstLvlSann,
                 RstPeriodUs);
    test_random(15, 74);
    write_levels($urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom_range(1, 100000));
    test_random(74, 15);
    write_levels(17'd65535, 17'd0, 17'd65535, 17'd0, 17'd1, 17'd100000);
    test_random(0, 0);
    test_backpressure();

    if (expected_contour.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/apc_pkg.sv
rtl/apc_front.sv
rtl/apc_div.sv
rtl/apc_back.sv
rtl/accent_pitch_contour.sv
tb/testbench.sv
